// ===== rtl/core/circle_spiral_setpoint_generator_assert.svh =====
// assertion macros shared by the setpoint generator rtl
`ifndef CIRCLE_SPIRAL_SETPOINT_GENERATOR_ASSERT_SVH
`define CIRCLE_SPIRAL_SETPOINT_GENERATOR_ASSERT_SVH

// same-cycle implication on aclk, disabled in reset
`define CSG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, disabled in reset
`define CSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csg_pkg.sv =====
// types, constants and helper functions of the setpoint generator
package csg_pkg;

    localparam int DELTA_W     = 20;
    localparam int DEN_W       = 34;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 68;
    localparam int PHASE_BITS  = 24;
    // angular rate terms, w cubed needs 28 bits at the shortest period
    localparam int W_W         = 28;
    localparam int STEPS_W     = 6;
    localparam int CLIMB_W     = 41;
    localparam int RATE_NUM_W  = 45;
    localparam int RATE_SHIFT  = 12;
    localparam int ANGLE_SHIFT = 22;
    localparam int CORDIC_STEPS = 28;

    localparam logic [RATE_NUM_W-1:0] RATE_NUM   = 45'd26986075409000;
    localparam logic [DEN_W-1:0]      RATE_ROUND = 34'd2048;
    localparam logic [30:0]           HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [31:0]    CORDIC_GAIN = 32'sd652032874;
    localparam logic [23:0]           MIN_PERIOD = 24'd1000;
    localparam logic [23:0]           DEFAULT_PERIOD = 24'd100000;
    localparam logic [9:0]            MS_TO_US = 10'd1000;

    localparam logic [5:0] RND_RATE  = 6'd20;
    localparam logic [5:0] RND_TRIG  = 6'd30;
    localparam logic [5:0] RND_PHASE = 6'd24;

    typedef enum logic [1:0] {
        MODE_POINT, MODE_CIRCLE, MODE_SPIRAL, MODE_OFF
    } csg_mode_t;

    typedef enum logic [2:0] {
        REG_MODE, REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z,
        REG_RADIUS, REG_PERIOD, REG_DESCENT
    } csg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_MSTORE, S_CORDIC, S_OUT
    } csg_state_t;

    typedef enum logic [1:0] {
        DIV_TIME, DIV_PHASE, DIV_RATE, DIV_CLIMB
    } csg_div_op_t;

    typedef enum logic [3:0] {
        M_ANGLE, M_W2, M_W3, M_RS, M_RC, M_VX, M_VY,
        M_AX, M_AY, M_JX, M_JY, M_ZQ, M_ZP
    } csg_mul_op_t;

    typedef struct packed {
        logic               start;
        logic [STEPS_W-1:0] steps;
    } csg_div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } csg_div_sts_t;

    // atan(2^-i) in q30
    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] a;
        a = '0;
        case (i)
            5'd0: a = 32'sd843314857;
            5'd1: a = 32'sd497837829;
            5'd2: a = 32'sd263043837;
            5'd3: a = 32'sd133525159;
            5'd4: a = 32'sd67021687;
            5'd5: a = 32'sd33543516;
            5'd6: a = 32'sd16775851;
            5'd7: a = 32'sd8388437;
            5'd8: a = 32'sd4194283;
            5'd9: a = 32'sd2097149;
            default: a[5'd30 - i] = 1'b1;
        endcase
        return a;
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v, input logic [5:0] s);
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) << (s - 6'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1) begin
            r = v[31:0];
        end else if (v[PROD_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/circle_spiral_setpoint_generator.sv =====
// top level of the circle and spiral setpoint generator
// point mode and mode three go straight to the output register; circle and spiral mode
//   run four divisions on the shared bit-serial divider, 28 cordic steps and 13 products
//   on the shared multiplier
// one item is worked on at a time; s_ready is high only while the sequencer is idle
// the output register lets the next item start while a result waits for m_ready
// reset (aresetn low, synchronous): elapsed time, configuration registers and handshake state clear
`include "circle_spiral_setpoint_generator_assert.svh"
module circle_spiral_setpoint_generator import csg_pkg::*; #(
    parameter int TIME_BITS = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // tick items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DELTA_W-1:0]  s_delta_us,
    // setpoint items
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_pos_x,
    output logic signed [31:0]  m_pos_y,
    output logic signed [31:0]  m_pos_z,
    output logic signed [31:0]  m_vel_x,
    output logic signed [31:0]  m_vel_y,
    output logic signed [31:0]  m_vel_z,
    output logic signed [31:0]  m_acc_x,
    output logic signed [31:0]  m_acc_y,
    output logic signed [31:0]  m_acc_z,
    output logic signed [31:0]  m_jerk_x,
    output logic signed [31:0]  m_jerk_y,
    output logic signed [31:0]  m_jerk_z
);

    // dividend width covers the time counter and the rate constant
    localparam int NUM_W = (TIME_BITS > RATE_NUM_W) ? TIME_BITS : RATE_NUM_W;
    // the period in microseconds is at least 1e6, so whole turns fit in this
    localparam int Q_W   = TIME_BITS - 19;

    // configuration registers
    csg_mode_t          mode_reg;
    logic signed [31:0] target_x_reg, target_y_reg, target_z_reg;
    logic signed [31:0] radius_reg, descent_reg;
    logic [23:0]        period_reg;

    // sequencer
    csg_state_t         state_reg, state_next;
    csg_div_op_t        div_op_reg, div_op_next;
    csg_mul_op_t        mop_reg, mop_next;
    logic [4:0]         it_reg, it_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_load;

    // time counter
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [TIME_BITS:0]   elapsed_sum;

    // divider hookup
    csg_div_cmd_t       div_cmd;
    csg_div_sts_t       div_sts;
    logic [NUM_W-1:0]   div_num, div_quot, rate_sum;
    logic [DEN_W-1:0]   div_den, div_rem_init, div_rem;

    // period and derived values
    logic [23:0]               per_eff;
    logic [DEN_W-1:0]          per_us;
    logic signed [CLIMB_W:0]   climb_num;
    logic [CLIMB_W-1:0]        climb_abs;
    logic signed [PROD_W-1:0]  climb_mag, climb_val;

    // datapath registers
    logic [Q_W-1:0]            q_reg;
    logic [PHASE_BITS-1:0]     phase_reg;
    logic [W_W-1:0]            w1_reg, w2_reg, w3_reg;
    logic signed [MUL_W-1:0]   rs_reg, rc_reg;
    logic signed [PROD_W-1:0]  zq_reg, prod_reg;
    logic signed [31:0]        vel_z_reg;
    logic signed [31:0]        vel_x_reg, vel_y_reg, acc_x_reg, acc_y_reg;
    logic signed [31:0]        jerk_x_reg, jerk_y_reg, pos_z_reg;

    // cordic
    logic signed [31:0]        cx_reg, cy_reg, cz_reg, cdx, cdy, cat;
    logic signed [MUL_W-1:0]   sin_val, cos_val, cx_ext, cy_ext;

    // shared multiplier operands
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_rnd;

    // output register
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;
    logic signed [31:0] o_acc_x, o_acc_y, o_jerk_x, o_jerk_y;
    logic signed [31:0] pos_x_reg, pos_y_reg, pz_out_reg, vx_out_reg, vy_out_reg;
    logic signed [31:0] vz_out_reg, ax_out_reg, ay_out_reg, jx_out_reg, jy_out_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // saturating microsecond counter
    assign elapsed_sum = {1'b0, elapsed_reg} + (TIME_BITS+1)'(s_delta_us);

    // a short period falls back to the default round time
    assign per_eff   = (period_reg < MIN_PERIOD) ? DEFAULT_PERIOD : period_reg;
    assign per_us    = DEN_W'(per_eff) * DEN_W'(MS_TO_US);
    assign climb_num = (CLIMB_W+1)'(descent_reg) * (CLIMB_W+1)'(MS_TO_US);
    assign climb_abs = climb_num[CLIMB_W] ? CLIMB_W'(-climb_num) : climb_num[CLIMB_W-1:0];

    // floor of descent*1000/T: negative values round away from zero on the magnitude
    assign climb_mag = PROD_W'(div_quot)
                     + PROD_W'(descent_reg[31] && (div_rem != '0));
    assign climb_val = descent_reg[31] ? -climb_mag : climb_mag;
    assign rate_sum  = div_quot + NUM_W'(RATE_ROUND);

    // divider operand select
    always_comb begin
        div_cmd.start = (state_reg == S_DIV_GO);
        div_num       = '0;
        div_den       = per_us;
        div_rem_init  = '0;
        div_cmd.steps = STEPS_W'(TIME_BITS);
        case (div_op_reg)
            DIV_TIME: begin
                div_num = NUM_W'(elapsed_reg) << (NUM_W - TIME_BITS);
            end
            DIV_PHASE: begin
                // continue from the time remainder, fraction of a turn
                div_rem_init  = div_rem;
                div_cmd.steps = STEPS_W'(PHASE_BITS);
            end
            DIV_RATE: begin
                div_num       = NUM_W'(RATE_NUM) << (NUM_W - RATE_NUM_W);
                div_den       = DEN_W'(per_eff);
                div_cmd.steps = STEPS_W'(RATE_NUM_W);
            end
            DIV_CLIMB: begin
                div_num       = NUM_W'(climb_abs) << (NUM_W - CLIMB_W);
                div_den       = DEN_W'(per_eff);
                div_cmd.steps = STEPS_W'(CLIMB_W);
            end
            default: begin
                div_num = '0;
            end
        endcase
    end

    csg_div #(
        .NUM_W(NUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .num      (div_num),
        .den      (div_den),
        .rem_init (div_rem_init),
        .sts      (div_sts),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // cordic step and quadrant fold
    assign cdx    = cy_reg >>> it_reg;
    assign cdy    = cx_reg >>> it_reg;
    assign cat    = atan_q30(it_reg);
    assign cx_ext = MUL_W'(cx_reg);
    assign cy_ext = MUL_W'(cy_reg);

    always_comb begin
        case (phase_reg[PHASE_BITS-1 -: 2])
            2'd0: begin
                sin_val = cy_ext;
                cos_val = cx_ext;
            end
            2'd1: begin
                sin_val = cx_ext;
                cos_val = -cy_ext;
            end
            2'd2: begin
                sin_val = -cy_ext;
                cos_val = -cx_ext;
            end
            default: begin
                sin_val = -cx_ext;
                cos_val = cy_ext;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mop_reg)
            M_ANGLE: begin
                mul_a = MUL_W'(phase_reg[ANGLE_SHIFT-1:0]);
                mul_b = MUL_W'(HALF_PI_Q30);
            end
            M_W2: begin
                mul_a = MUL_W'(w1_reg);
                mul_b = MUL_W'(w1_reg);
            end
            M_W3: begin
                mul_a = MUL_W'(w2_reg);
                mul_b = MUL_W'(w1_reg);
            end
            M_RS: begin
                mul_a = MUL_W'(radius_reg);
                mul_b = sin_val;
            end
            M_RC: begin
                mul_a = MUL_W'(radius_reg);
                mul_b = cos_val;
            end
            M_VX: begin
                mul_a = rc_reg;
                mul_b = MUL_W'(w1_reg);
            end
            M_VY: begin
                mul_a = rs_reg;
                mul_b = MUL_W'(w1_reg);
            end
            M_AX: begin
                mul_a = rs_reg;
                mul_b = MUL_W'(w2_reg);
            end
            M_AY: begin
                mul_a = rc_reg;
                mul_b = MUL_W'(w2_reg);
            end
            M_JX: begin
                mul_a = rc_reg;
                mul_b = MUL_W'(w3_reg);
            end
            M_JY: begin
                mul_a = rs_reg;
                mul_b = MUL_W'(w3_reg);
            end
            M_ZQ: begin
                mul_a = MUL_W'(descent_reg);
                mul_b = MUL_W'(q_reg);
            end
            M_ZP: begin
                mul_a = MUL_W'(descent_reg);
                mul_b = MUL_W'(phase_reg);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // rounding shift of the registered product depends on the product kind
    always_comb begin
        case (mop_reg)
            M_RS, M_RC: prod_rnd = rnd_shift(prod_reg, RND_TRIG);
            M_ZP:       prod_rnd = rnd_shift(prod_reg, RND_PHASE);
            default:    prod_rnd = rnd_shift(prod_reg, RND_RATE);
        endcase
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        div_op_next  = div_op_reg;
        mop_next     = mop_reg;
        it_next      = it_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (mode_reg == MODE_CIRCLE || mode_reg == MODE_SPIRAL) begin
                        state_next  = S_DIV_GO;
                        div_op_next = DIV_TIME;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV_GO: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_sts.done) begin
                    if (div_op_reg == DIV_CLIMB) begin
                        state_next = S_MUL;
                        mop_next   = M_ANGLE;
                    end else begin
                        state_next  = S_DIV_GO;
                        div_op_next = csg_div_op_t'(div_op_reg + 1'b1);
                    end
                end
            end
            S_MUL: begin
                state_next = S_MSTORE;
            end
            S_MSTORE: begin
                if (mop_reg == M_ANGLE) begin
                    state_next = S_CORDIC;
                    it_next    = '0;
                end else if (mop_reg == M_ZP) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_MUL;
                    mop_next   = csg_mul_op_t'(mop_reg + 1'b1);
                end
            end
            S_CORDIC: begin
                it_next = it_reg + 1'b1;
                if (it_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = S_MUL;
                    mop_next   = M_W2;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, time counter and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_op_reg   <= DIV_TIME;
            mop_reg      <= M_ANGLE;
            it_reg       <= '0;
            m_valid_reg  <= 1'b0;
            elapsed_reg  <= '0;
            mode_reg     <= MODE_POINT;
            target_x_reg <= '0;
            target_y_reg <= '0;
            target_z_reg <= '0;
            radius_reg   <= '0;
            period_reg   <= '0;
            descent_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            div_op_reg  <= div_op_next;
            mop_reg     <= mop_next;
            it_reg      <= it_next;
            m_valid_reg <= m_valid_next;
            if (s_valid && s_ready) begin
                // counter stops at all ones
                elapsed_reg <= elapsed_sum[TIME_BITS] ? '1 : elapsed_sum[TIME_BITS-1:0];
            end
            if (cfg_valid && cfg_ready) begin
                case (csg_reg_t'(cfg_index))
                    REG_MODE:     mode_reg     <= csg_mode_t'(cfg_data[1:0]);
                    REG_TARGET_X: target_x_reg <= cfg_data;
                    REG_TARGET_Y: target_y_reg <= cfg_data;
                    REG_TARGET_Z: target_z_reg <= cfg_data;
                    REG_RADIUS:   radius_reg   <= cfg_data;
                    REG_PERIOD:   period_reg   <= cfg_data[23:0];
                    REG_DESCENT:  descent_reg  <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == S_DIV_WAIT && div_sts.done) begin
            case (div_op_reg)
                DIV_TIME:  q_reg     <= div_quot[Q_W-1:0];
                DIV_PHASE: phase_reg <= div_quot[PHASE_BITS-1:0];
                DIV_RATE:  w1_reg    <= rate_sum[RATE_SHIFT +: W_W];
                DIV_CLIMB: vel_z_reg <= sat32(climb_val);
                default:   ;
            endcase
        end
        if (state_reg == S_MUL) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (state_reg == S_MSTORE) begin
            case (mop_reg)
                M_ANGLE: begin
                    // start from the gain-compensated unit vector
                    cx_reg <= CORDIC_GAIN;
                    cy_reg <= '0;
                    cz_reg <= prod_reg[ANGLE_SHIFT +: 32];
                end
                M_W2:    w2_reg     <= prod_rnd[W_W-1:0];
                M_W3:    w3_reg     <= prod_rnd[W_W-1:0];
                M_RS:    rs_reg     <= prod_rnd[MUL_W-1:0];
                M_RC:    rc_reg     <= prod_rnd[MUL_W-1:0];
                M_VX:    vel_x_reg  <= sat32(prod_rnd);
                M_VY:    vel_y_reg  <= sat32(prod_rnd);
                M_AX:    acc_x_reg  <= sat32(-prod_rnd);
                M_AY:    acc_y_reg  <= sat32(prod_rnd);
                M_JX:    jerk_x_reg <= sat32(-prod_rnd);
                M_JY:    jerk_y_reg <= sat32(-prod_rnd);
                M_ZQ:    zq_reg     <= prod_reg;
                M_ZP:    pos_z_reg  <= sat32(zq_reg + prod_rnd);
                default: ;
            endcase
        end
        if (state_reg == S_CORDIC) begin
            if (!cz_reg[31]) begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - cat;
            end else begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + cat;
            end
        end
        if (out_load) begin
            pos_x_reg  <= o_pos_x;
            pos_y_reg  <= o_pos_y;
            pz_out_reg <= o_pos_z;
            vx_out_reg <= o_vel_x;
            vy_out_reg <= o_vel_y;
            vz_out_reg <= o_vel_z;
            ax_out_reg <= o_acc_x;
            ay_out_reg <= o_acc_y;
            jx_out_reg <= o_jerk_x;
            jy_out_reg <= o_jerk_y;
        end
    end

    // result assembly per mode; mode three gives all zeros
    always_comb begin
        o_pos_x  = '0;
        o_pos_y  = '0;
        o_pos_z  = '0;
        o_vel_x  = '0;
        o_vel_y  = '0;
        o_vel_z  = '0;
        o_acc_x  = '0;
        o_acc_y  = '0;
        o_jerk_x = '0;
        o_jerk_y = '0;
        case (mode_reg)
            MODE_POINT: begin
                o_pos_x = target_x_reg;
                o_pos_y = target_y_reg;
                o_pos_z = target_z_reg;
            end
            MODE_CIRCLE, MODE_SPIRAL: begin
                o_pos_x  = sat32(PROD_W'(rs_reg));
                o_pos_y  = sat32(PROD_W'(radius_reg) - PROD_W'(rc_reg));
                o_vel_x  = vel_x_reg;
                o_vel_y  = vel_y_reg;
                o_acc_x  = acc_x_reg;
                o_acc_y  = acc_y_reg;
                o_jerk_x = jerk_x_reg;
                o_jerk_y = jerk_y_reg;
                if (mode_reg == MODE_SPIRAL) begin
                    o_pos_z = pos_z_reg;
                    o_vel_z = vel_z_reg;
                end
            end
            default: begin
                o_pos_x = '0;
            end
        endcase
    end

    assign m_pos_x  = pos_x_reg;
    assign m_pos_y  = pos_y_reg;
    assign m_pos_z  = pz_out_reg;
    assign m_vel_x  = vx_out_reg;
    assign m_vel_y  = vy_out_reg;
    assign m_vel_z  = vz_out_reg;
    assign m_acc_x  = ax_out_reg;
    assign m_acc_y  = ay_out_reg;
    assign m_acc_z  = '0;
    assign m_jerk_x = jx_out_reg;
    assign m_jerk_y = jy_out_reg;
    assign m_jerk_z = '0;

    // checks
    `CSG_ASSERT_IMP(a_idle_divider, s_ready, !div_sts.busy, "item taken while divider busy")
    `CSG_ASSERT_NEXT(a_time_forward, s_valid && s_ready, elapsed_reg >= $past(elapsed_reg), "elapsed time went backwards")
    `CSG_ASSERT_NEXT(a_point_still, out_load && mode_reg == MODE_POINT, m_valid && m_vel_x == '0 && m_jerk_y == '0, "point mode result moves")

endmodule

// ===== rtl/core/csg_div.sv =====
// restoring divider, one quotient bit per cycle
module csg_div import csg_pkg::*; #(
    parameter int NUM_W = 45
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  csg_div_cmd_t       cmd,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    input  logic [DEN_W-1:0]   rem_init,
    output csg_div_sts_t       sts,
    output logic [NUM_W-1:0]   quot,
    output logic [DEN_W-1:0]   rem
);

    logic [NUM_W-1:0]   num_reg, num_next, quot_reg, quot_next;
    logic [DEN_W-1:0]   den_reg, den_next, rem_reg, rem_next;
    logic [STEPS_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]     trial, diff;

    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            num_next  = num;
            quot_next = '0;
            den_next  = den;
            rem_next  = rem_init;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            // borrow clear means the divisor fits
            quot_next = {quot_reg[NUM_W-2:0], !diff[DEN_W]};
            rem_next  = diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == STEPS_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = quot_reg;
    assign rem      = rem_reg;

endmodule
